@@ design/hpcks_pkg.sv @@
package hpcks_pkg;

	localparam int HPCKS_MAX_K   = 32;
	localparam int HPCKS_K_MIN   = 5;
	localparam int HPCKS_K_RESET = 16;
	localparam int HPCKS_KMER_W  = 64;
	localparam int HPCKS_POS_W   = 32;
	localparam int HPCKS_ID_W    = 32;
	localparam int HPCKS_CFG_W   = 6;

	localparam logic [2:0] HPCKS_NO_BASE = 3'd4;

	typedef struct packed {
		logic [HPCKS_KMER_W-1:0] kmer;
		logic                    dir;
		logic                    palin;
	} canon_t;

endpackage

@@ design/hpcks_canon.sv @@
module hpcks_canon
	import hpcks_pkg::*;
#(
	parameter int MAX_K = HPCKS_MAX_K,
	localparam int WIN_W = 2 * MAX_K,
	localparam int KW = $clog2(MAX_K + 1)
) (
	input  logic [WIN_W-1:0] win,
	input  logic [KW-1:0]    k,
	output canon_t           canon
);

	logic [WIN_W-1:0] rev_full;
	logic [WIN_W-1:0] rev;
	logic [KW-1:0]    diff;
	logic             rev_le;

	// complement and base reversal over the full window, then align to k
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			rev_full[2*(MAX_K-1-i) +: 2] = ~win[2*i +: 2];
		end
	end

	assign diff   = KW'(MAX_K) - k;
	assign rev    = rev_full >> {diff, 1'b0};
	assign rev_le = !(rev > win);

	always_comb begin
		canon.palin = (rev == win);
		canon.dir   = rev_le;
		canon.kmer  = rev_le ? HPCKS_KMER_W'(rev) : HPCKS_KMER_W'(win);
	end

endmodule

@@ design/hpc_canonical_kmer_seeder_unit.sv @@
// A base is held in the input register, then its seed is written to the result register.
// Throughput: one base per cycle unless a seed stalls, set by the single pass through the
// window update, reverse complement and 64-bit compare between the input and result registers.
// Reset (arst_n low, asynchronous): k = 16, read state cleared, no seed pending.
// The start position shift line has no reset and is only read after being written.
module hpc_canonical_kmer_seeder_unit
	import hpcks_pkg::*;
#(
	parameter int MAX_K = HPCKS_MAX_K
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_wr_en,
	input  logic [HPCKS_CFG_W-1:0]  cfg_wr_data,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              base,
	input  logic                    first_of_read,
	input  logic [HPCKS_ID_W-1:0]   read_id,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [HPCKS_KMER_W-1:0] seed_kmer,
	output logic                    seed_dir,
	output logic [HPCKS_ID_W-1:0]   seed_read,
	output logic [HPCKS_POS_W-1:0]  seed_offset,
	output logic [HPCKS_POS_W-1:0]  seed_span
);

	localparam int WIN_W = 2 * MAX_K;
	localparam int KW    = $clog2(MAX_K + 1);
	localparam int IW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int K_RST = (HPCKS_K_RESET > MAX_K) ? MAX_K : HPCKS_K_RESET;

	logic [KW-1:0] k_q;
	logic [KW-1:0] k_wr;

	always_comb begin
		if (cfg_wr_data < HPCKS_CFG_W'(HPCKS_K_MIN)) begin
			k_wr = KW'(HPCKS_K_MIN);
		end else if ({1'b0, cfg_wr_data} > (HPCKS_CFG_W + 1)'(MAX_K)) begin
			k_wr = KW'(MAX_K);
		end else begin
			k_wr = KW'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KW'(K_RST);
		end else if (cfg_wr_en) begin
			k_q <= k_wr;
		end
	end

	// input register
	logic                  valid_s1;
	logic [1:0]            base_s1;
	logic                  first_s1;
	logic [HPCKS_ID_W-1:0] rid_s1;
	logic                  process;
	logic                  out_valid_q;

	assign process  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			base_s1  <= base;
			first_s1 <= first_of_read;
			rid_s1   <= read_id;
		end
	end

	// read state
	logic [2:0]             prev_q;
	logic [WIN_W-1:0]       win_q;
	logic [KW-1:0]          kept_q;
	logic [HPCKS_POS_W-1:0] rpos_q;
	logic [HPCKS_POS_W-1:0] sp_q [MAX_K];

	logic [2:0]             cur_prev;
	logic [WIN_W-1:0]       cur_win;
	logic [KW-1:0]          cur_kept;
	logic [HPCKS_POS_W-1:0] pos;
	logic [HPCKS_POS_W-1:0] next_rpos;
	logic                   keep;
	logic [WIN_W-1:0]       win_mask;
	logic [WIN_W-1:0]       new_win;
	logic [KW-1:0]          new_kept;
	logic [HPCKS_POS_W-1:0] sp_shift [MAX_K];
	logic [IW-1:0]          start_idx;
	logic [HPCKS_POS_W-1:0] start;
	logic                   emit;
	canon_t                 canon;

	always_comb begin
		cur_prev = first_s1 ? HPCKS_NO_BASE : prev_q;
		cur_win  = first_s1 ? '0 : win_q;
		cur_kept = first_s1 ? '0 : kept_q;
		pos      = first_s1 ? '0 : rpos_q;
	end

	assign next_rpos = (pos == '1) ? pos : pos + 1'b1;
	assign keep      = ({1'b0, base_s1} != cur_prev);

	always_comb begin
		for (int j = 0; j < MAX_K; j++) begin
			win_mask[2*j +: 2] = {2{KW'(j) < k_q}};
		end
	end

	assign new_win  = {cur_win[WIN_W-3:0], base_s1} & win_mask;
	assign new_kept = (cur_kept == KW'(MAX_K)) ? cur_kept : cur_kept + 1'b1;

	always_comb begin
		sp_shift[0] = pos;
		for (int i = 1; i < MAX_K; i++) begin
			sp_shift[i] = sp_q[i-1];
		end
	end

	assign start_idx = IW'(k_q - 1'b1) & IW'(MAX_K - 1);
	assign start     = sp_shift[start_idx];

	hpcks_canon #(
		.MAX_K(MAX_K)
	) u_canon (
		.win  (new_win),
		.k    (k_q),
		.canon(canon)
	);

	assign emit = keep && (new_kept >= k_q) && !canon.palin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= HPCKS_NO_BASE;
			win_q  <= '0;
			kept_q <= '0;
			rpos_q <= '0;
		end else if (process) begin
			rpos_q <= next_rpos;
			if (keep) begin
				prev_q <= {1'b0, base_s1};
				win_q  <= new_win;
				kept_q <= new_kept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (process && keep) begin
			sp_q <= sp_shift;
		end
	end

	// result register
	logic [HPCKS_KMER_W-1:0] seed_kmer_q;
	logic                    seed_dir_q;
	logic [HPCKS_ID_W-1:0]   seed_read_q;
	logic [HPCKS_POS_W-1:0]  seed_offset_q;
	logic [HPCKS_POS_W-1:0]  seed_span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit) begin
			seed_kmer_q   <= canon.kmer;
			seed_dir_q    <= canon.dir;
			seed_read_q   <= rid_s1;
			seed_offset_q <= start;
			seed_span_q   <= pos + 1'b1 - start;
		end
	end

	assign out_valid   = out_valid_q;
	assign seed_kmer   = seed_kmer_q;
	assign seed_dir    = seed_dir_q;
	assign seed_read   = seed_read_q;
	assign seed_offset = seed_offset_q;
	assign seed_span   = seed_span_q;

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= KW'(MAX_K))
		else $error("kept count above MAX_K");

	a_prev_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(prev_q != HPCKS_NO_BASE) |-> (kept_q != '0))
		else $error("base held with empty window count");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q >= KW'(HPCKS_K_MIN)) && (k_q <= KW'(MAX_K)))
		else $error("k outside legal range");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1) |-> !in_ready)
		else $error("input taken while result stalled and stage full");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !process) |=> (valid_s1 && $stable(base_s1) && $stable(rid_s1)))
		else $error("stalled input stage changed");

endmodule
